// ===== src/ordered_list_insert_delete_assert.svh =====
// Assertion macros for the ordered list block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ORDERED_LIST_INSERT_DELETE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTHESIS
// property holds at every rising clock edge outside reset
`define OLID_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be true outside reset
`define OLID_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define OLID_ASSERT(name, clk, rstn, prop, msg)
`define OLID_NEVER(name, clk, rstn, cond, msg)
`endif

`endif

// ===== src/olid_pkg.sv =====
// Shared types and constants of the ordered list block.
// Used by olid_cell and ordered_list_insert_delete; no dependencies.
package olid_pkg;

    // field widths of a transaction
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 5;
    localparam int POS2_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 5;
    localparam int DOUT_W   = 32;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // configuration register map
    localparam int          PADDR_W  = 3;
    localparam logic [2:0]  ADDR_CAP = 3'd0;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // request opcodes
    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_SWAP   = 3'd4
    } op_t;

    // what the cell row does this cycle
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_SWAP   = 2'd3
    } act_t;

    // command broadcast to every cell
    typedef struct packed {
        act_t              act;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  pos2;
        logic [LEN_W-1:0]  fill;
    } olid_cmd_t;

endpackage

// ===== src/olid_cell.sv =====
// One storage cell of the list: holds a single entry and shifts with its neighbors.
// Depends on olid_pkg for the command struct.
module olid_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                    aclk,
    input  olid_pkg::olid_cmd_t     cmd,
    input  logic [DATA_WIDTH-1:0]   new_word,
    input  logic [DATA_WIDTH-1:0]   left_word,
    input  logic [DATA_WIDTH-1:0]   right_word,
    input  logic [DATA_WIDTH-1:0]   word_a,
    input  logic [DATA_WIDTH-1:0]   word_b,
    output logic [DATA_WIDTH-1:0]   word,
    output logic [DATA_WIDTH-1:0]   tap_a,
    output logic [DATA_WIDTH-1:0]   tap_b
);
    import olid_pkg::*;

    localparam logic [8:0] MY_IDX   = 9'(INDEX);
    localparam logic [8:0] NEXT_IDX = 9'(INDEX + 1);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic [8:0]            pos_w;
    logic [8:0]            pos2_w;
    logic [8:0]            fill_w;

    assign pos_w  = {4'b0, cmd.pos};
    assign pos2_w = {4'b0, cmd.pos2};
    assign fill_w = {4'b0, cmd.fill};

    // next entry: hold, take a neighbor, or load a new or swapped word
    always_comb begin
        word_next = word_reg;
        unique case (cmd.act)
            ACT_INSERT: begin
                if (MY_IDX == pos_w) begin
                    word_next = new_word;
                end else if (MY_IDX > pos_w && MY_IDX <= fill_w) begin
                    word_next = left_word;
                end
            end
            ACT_DELETE: begin
                if (MY_IDX >= pos_w && NEXT_IDX < fill_w) begin
                    word_next = right_word;
                end
            end
            ACT_SWAP: begin
                if (MY_IDX == pos_w) begin
                    word_next = word_b;
                end else if (MY_IDX == pos2_w) begin
                    word_next = word_a;
                end
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // contributions to the two read buses
    assign word  = word_reg;
    assign tap_a = (MY_IDX == pos_w)  ? word_reg : '0;
    assign tap_b = (MY_IDX == pos2_w) ? word_reg : '0;

endmodule

// ===== src/ordered_list_insert_delete.sv =====
// Ordered list of data words built as a row of shifting cells.
// Top level; depends on olid_pkg, olid_cell and ordered_list_insert_delete_assert.svh.
//
// A fixed-capacity ordered list. For each request (read, append, insert, delete, swap)
// the request is accepted, every cell of the row loads its next entry in parallel and
// the response lands in an output register, readable in the cycle after acceptance, so
// a new request is taken every cycle while the response side keeps up, and also while
// one response waits if the consumer takes it in that cycle. The rate is set by the
// parallel update of the cell row. Rejected requests (out of range, full, empty,
// unused opcode) return ok = 0 and leave the list unchanged. capacity_limit (byte
// address 0) should be written only while no response is pending. Entries have no
// reset; the length check keeps every read inside written entries.
`include "ordered_list_insert_delete_assert.svh"

module ordered_list_insert_delete #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[2:0], position[7:3], other_position[11:8], value[43:12], pad[47:44]
    input  logic [olid_pkg::S_TDATA_W-1:0]  s_tdata,
    // response stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ok[0], data_out[32:1], length_now[37:33], is_empty[38], pad[39]
    output logic [olid_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [olid_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import olid_pkg::*;

    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

    // request fields
    logic [OPCODE_W-1:0] opcode;
    logic [POS_W-1:0]    position;
    logic [POS2_W-1:0]   other_position;
    logic [VALUE_W-1:0]  value;

    assign opcode         = s_tdata[2:0];
    assign position       = s_tdata[7:3];
    assign other_position = s_tdata[11:8];
    assign value          = s_tdata[43:12];

    logic [LEN_W-1:0]          fill_reg, fill_next;
    logic [4:0]                cap_reg;
    logic [LEN_W-1:0]          eff_cap;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      s_acc;
    logic                      ok;
    logic                      returns_word;
    act_t                      act;
    logic [POS_W-1:0]          cmd_pos;
    olid_cmd_t                 cmd;
    logic [DATA_WIDTH-1:0]     rd_a, rd_b;
    logic [DOUT_W-1:0]         data_out;
    logic                      room, pos_in, pos2_in;

    logic [DATA_WIDTH-1:0] words [DEPTH];
    logic [DATA_WIDTH-1:0] taps_a [DEPTH];
    logic [DATA_WIDTH-1:0] taps_b [DEPTH];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // bound checks
    assign eff_cap = (cap_reg > 5'(CAP_MAX)) ? 5'(CAP_MAX) : cap_reg;
    assign room    = fill_reg < eff_cap;
    assign pos_in  = position < fill_reg;
    assign pos2_in = {1'b0, other_position} < fill_reg;

    // opcode decode
    always_comb begin
        ok           = 1'b0;
        returns_word = 1'b0;
        act          = ACT_NONE;
        cmd_pos      = position;
        unique case (opcode)
            OP_READ: begin
                ok           = pos_in;
                returns_word = 1'b1;
            end
            OP_APPEND: begin
                ok      = room;
                act     = ACT_INSERT;
                cmd_pos = fill_reg;
            end
            OP_INSERT: begin
                ok  = room && (position <= fill_reg);
                act = ACT_INSERT;
            end
            OP_DELETE: begin
                ok           = pos_in;
                returns_word = 1'b1;
                act          = ACT_DELETE;
            end
            OP_SWAP: begin
                ok  = pos_in && pos2_in;
                act = ACT_SWAP;
            end
            default: ok = 1'b0;
        endcase
    end

    assign cmd.act  = (s_acc && ok) ? act : ACT_NONE;
    assign cmd.pos  = cmd_pos;
    assign cmd.pos2 = {1'b0, other_position};
    assign cmd.fill = fill_reg;

    // row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = words[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = words[i+1];
        end
        olid_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .new_word   (DATA_WIDTH'(value)),
            .left_word  (left_w),
            .right_word (right_w),
            .word_a     (rd_a),
            .word_b     (rd_b),
            .word       (words[i]),
            .tap_a      (taps_a[i]),
            .tap_b      (taps_b[i])
        );
    end

    // read buses: at most one cell drives each
    always_comb begin
        rd_a = '0;
        rd_b = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_a = rd_a | taps_a[i];
            rd_b = rd_b | taps_b[i];
        end
    end

    assign data_out = (ok && returns_word) ? DOUT_W'(rd_a) : '0;

    // length update
    always_comb begin
        fill_next = fill_reg;
        if (s_acc && ok) begin
            case (act)
                ACT_INSERT: fill_next = fill_reg + 5'd1;
                ACT_DELETE: fill_next = fill_reg - 5'd1;
                default:    fill_next = fill_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // response register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_acc) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_tdata_reg <= {1'b0, (fill_next == '0), fill_next, data_out, ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CAP) begin
            cap_reg <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAP) ? {27'b0, cap_reg} : 32'b0;

    // checks
    `OLID_ASSERT(a_reject_keeps_len, aclk, aresetn, (s_acc && !ok) |=> $stable(fill_reg), "rejected transaction changed length")
    `OLID_ASSERT(a_idle_keeps_len, aclk, aresetn, !s_acc |=> $stable(fill_reg), "length changed without a transaction")
    `OLID_ASSERT(a_delete_len, aclk, aresetn, (s_acc && ok && act == ACT_DELETE) |=> (fill_reg == $past(fill_reg) - 5'd1), "delete did not shorten list")
    `OLID_ASSERT(a_empty_flag, aclk, aresetn, m_tvalid_reg |-> (m_tdata_reg[38] == (m_tdata_reg[37:33] == 5'd0)), "empty flag disagrees with length")
    `OLID_NEVER(a_len_cap, aclk, aresetn, fill_reg > 5'(CAP_MAX), "length above capacity")

endmodule

// ===== sim/tb_ordered_list_insert_delete.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the ordered list block: a directed table, then random phases
// at several capacity limits, every response checked against a typed row or a shadow list.
// Depends on olid_pkg and the ordered_list_insert_delete RTL.
module tb_ordered_list_insert_delete;
    import olid_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int DIR_N        = 26;
    localparam int PHASE_ITEMS  = 215;
    localparam int N_PHASES     = 9;
    localparam int GROW_TAIL    = 40;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;

    // opcodes the block must reject
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    pos;
        logic [POS2_W-1:0]   pos2;
        logic [VALUE_W-1:0]  value;
    } list_req_t;

    typedef struct packed {
        logic              ok;
        logic [DOUT_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              empty;
    } list_resp_t;

    // chk set: the response is typed in the row, else it comes from the shadow list
    typedef struct packed {
        list_req_t  req;
        logic       chk;
        list_resp_t resp;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_THROTTLE, RX_CHOKE} rx_mode_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // {pad, value, other_position, position, opcode} from the top bit down: opcode at bit 0
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // ok, data_out, length_now, is_empty, pad from bit 0 up
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    ordered_list_insert_delete #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow list and its capacity register
    logic [DATA_WIDTH-1:0] list_words [DEPTH];
    int                    list_len  = 0;
    logic [LEN_W-1:0]      cap_limit = CAP_RESET;

    list_resp_t awaited_replies [$];
    list_resp_t reply_want;

    int err_count    = 0;
    int req_count    = 0;
    int done_count   = 0;
    int reply_count  = 0;
    int peak_len     = 0;
    int stall_cycles = 0;
    int burst_left   = 0;
    int op_seen [8];
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;

    // directed table; list starts empty with capacity 16
    dir_row_t dir_rows [DIR_N] = '{
        // access on an empty list
        '{'{OP_READ,   5'd0,  4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
        '{'{OP_DELETE, 5'd0,  4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
        '{'{OP_SWAP,   5'd0,  4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
        '{'{OP_INSERT, 5'd1,  4'd0,  32'h1},        1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
        // build [A5, FF, 00, 5A]
        '{'{OP_APPEND, 5'd0,  4'd0,  32'hFFFFFFFF}, 1'b1, '{1'b1, 32'h0, 5'd1, 1'b0}},
        '{'{OP_APPEND, 5'd0,  4'd0,  32'h0},        1'b1, '{1'b1, 32'h0, 5'd2, 1'b0}},
        '{'{OP_INSERT, 5'd0,  4'd0,  32'hA5A5A5A5}, 1'b1, '{1'b1, 32'h0, 5'd3, 1'b0}},
        '{'{OP_INSERT, 5'd3,  4'd0,  32'h5A5A5A5A}, 1'b1, '{1'b1, 32'h0, 5'd4, 1'b0}},
        '{'{OP_INSERT, 5'd16, 4'd0,  32'h1234},     1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        // reads, including the one-past-the-end bound
        '{'{OP_READ,   5'd0,  4'd0,  32'h0},        1'b1, '{1'b1, 32'hA5A5A5A5, 5'd4, 1'b0}},
        '{'{OP_READ,   5'd4,  4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        '{'{OP_READ,   5'd16, 4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        '{'{OP_READ,   5'd3,  4'd0,  32'h0},        1'b0, '0},
        // swap, in and out of range
        '{'{OP_SWAP,   5'd0,  4'd3,  32'h0},        1'b1, '{1'b1, 32'h0, 5'd4, 1'b0}},
        '{'{OP_SWAP,   5'd15, 4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        '{'{OP_SWAP,   5'd0,  4'd15, 32'h0},        1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        '{'{OP_SWAP,   5'd2,  4'd2,  32'h0},        1'b0, '0},
        // unused opcodes
        '{'{OP_RSVD_5, 5'd0,  4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        '{'{OP_RSVD_6, 5'd1,  4'd1,  32'h1},        1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        '{'{OP_RSVD_7, 5'd16, 4'd15, 32'hFFFFFFFF}, 1'b1, '{1'b0, 32'h0, 5'd4, 1'b0}},
        // deletes down to empty
        '{'{OP_DELETE, 5'd1,  4'd0,  32'h0},        1'b0, '0},
        '{'{OP_DELETE, 5'd16, 4'd0,  32'h0},        1'b1, '{1'b0, 32'h0, 5'd3, 1'b0}},
        '{'{OP_DELETE, 5'd2,  4'd0,  32'h0},        1'b0, '0},
        '{'{OP_READ,   5'd1,  4'd0,  32'h0},        1'b0, '0},
        '{'{OP_DELETE, 5'd0,  4'd0,  32'h0},        1'b0, '0},
        '{'{OP_DELETE, 5'd0,  4'd0,  32'h0},        1'b0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("ERROR %0t: %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // apply one request to the shadow list and return the response it must give
    function automatic list_resp_t apply_request(input list_req_t r);
        list_resp_t res;
        int eff_cap;
        logic [DATA_WIDTH-1:0] held;
        res = '0;
        eff_cap = (cap_limit < DEPTH) ? int'(cap_limit) : DEPTH;
        case (r.opcode)
            OP_READ: begin
                if (r.pos < list_len) begin
                    res.ok   = 1'b1;
                    res.data = list_words[r.pos];
                end
            end
            OP_APPEND: begin
                if (list_len < eff_cap) begin
                    list_words[list_len] = r.value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            OP_INSERT: begin
                if (list_len < eff_cap && r.pos <= list_len) begin
                    for (int k = list_len; k > r.pos; k--)
                        list_words[k] = list_words[k-1];
                    list_words[r.pos] = r.value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (r.pos < list_len) begin
                    res.data = list_words[r.pos];
                    for (int k = r.pos; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            OP_SWAP: begin
                if (r.pos < list_len && r.pos2 < list_len) begin
                    held                = list_words[r.pos];
                    list_words[r.pos]   = list_words[r.pos2];
                    list_words[r.pos2]  = held;
                    res.ok = 1'b1;
                end
            end
            default: ;
        endcase
        res.len   = list_len[LEN_W-1:0];
        res.empty = (list_len == 0);
        return res;
    endfunction

    // random request; grow biases toward filling the list
    function automatic list_req_t random_request(input bit grow);
        list_req_t r;
        int pick;
        int pos2_top;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.opcode = OPCODE_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        else if (grow)
            r.opcode = pick < 35 ? OP_APPEND : pick < 65 ? OP_INSERT :
                       pick < 80 ? OP_READ : pick < 90 ? OP_SWAP : OP_DELETE;
        else
            r.opcode = pick < 15 ? OP_APPEND : pick < 25 ? OP_INSERT :
                       pick < 45 ? OP_READ : pick < 60 ? OP_SWAP : OP_DELETE;
        // mostly in range or just past the end, sometimes anywhere
        if ($urandom_range(0, 9) < 8)
            r.pos = POS_W'($urandom_range(0, list_len));
        else
            r.pos = POS_W'($urandom_range(0, DEPTH));
        pos2_top = (list_len < DEPTH) ? list_len : DEPTH - 1;
        if ($urandom_range(0, 9) < 8)
            r.pos2 = POS2_W'($urandom_range(0, pos2_top));
        else
            r.pos2 = POS2_W'($urandom_range(0, DEPTH - 1));
        case ($urandom_range(0, 7))
            0:       r.value = '0;
            1:       r.value = '1;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    // present one request in bursts with random gaps; entered and left at a falling edge
    task automatic send_request(input list_req_t r, input logic chk, input list_resp_t typed);
        list_resp_t predicted;
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.value, r.pos2, r.pos, r.opcode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_request(r);
        awaited_replies.push_back(chk ? typed : predicted);
        req_count++;
        op_seen[r.opcode]++;
        if (predicted.ok) done_count++;
        if (list_len > peak_len) peak_len = list_len;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write the capacity limit, then read it back
    task automatic set_capacity(input logic [LEN_W-1:0] cap);
        logic [31:0] rd;
        wait_idle();
        cfg_access(1'b1, ADDR_CAP, {27'b0, cap}, rd);
        cap_limit = cap;
        cfg_access(1'b0, ADDR_CAP, 32'h0, rd);
        if (rd !== {27'b0, cap}) report_mismatch("capacity_limit readback", {27'b0, cap}, rd);
    endtask

    // response checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            reply_count++;
            if (awaited_replies.size() == 0) begin
                report_mismatch("response with none outstanding", 32'h0, m_tdata[32:1]);
            end else begin
                reply_want = awaited_replies.pop_front();
                if (m_tdata[0] !== reply_want.ok)
                    report_mismatch("ok", 32'(reply_want.ok), 32'(m_tdata[0]));
                if (m_tdata[32:1] !== reply_want.data)
                    report_mismatch("data_out", reply_want.data, m_tdata[32:1]);
                if (m_tdata[37:33] !== reply_want.len)
                    report_mismatch("length_now", 32'(reply_want.len), 32'(m_tdata[37:33]));
                if (m_tdata[38] !== reply_want.empty)
                    report_mismatch("is_empty", 32'(reply_want.empty), 32'(m_tdata[38]));
            end
        end
    end

    // receiver: open, random, throttled and choked stretches
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
            RX_THROTTLE: m_tready <= (rx_left % 4 == 0);
            default:     m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [31:0] rd;
        logic [LEN_W-1:0] cap_plan [N_PHASES];
        bit grow;
        cap_plan = '{CAP_RESET, 5'd1, 5'd0, 5'd31, 5'd16, 5'd9, 5'd3, 5'd16, 5'd16};
        cap_plan[N_PHASES-1] = LEN_W'($urandom_range(1, 16));
        for (int i = 0; i < 8; i++) op_seen[i] = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset value of the register
        cfg_access(1'b0, ADDR_CAP, 32'h0, rd);
        if (rd !== {27'b0, CAP_RESET})
            report_mismatch("capacity_limit after reset", {27'b0, CAP_RESET}, rd);

        for (int i = 0; i < DIR_N; i++)
            send_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].resp);

        // random phases; each ends growing so the next limit may fall below the fill
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) set_capacity(cap_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                grow = (i >= PHASE_ITEMS - GROW_TAIL) || ((i / 30) % 2 == 0);
                send_request(random_request(grow), 1'b0, '0);
            end
        end

        wait_idle();
        $display("covered %0d requests (%0d done, %0d rejected), %0d responses, longest list %0d",
                 req_count, done_count, req_count - done_count, reply_count, peak_len);
        $display("per opcode read/append/insert/delete/swap/unused: %0d/%0d/%0d/%0d/%0d/%0d",
                 op_seen[OP_READ], op_seen[OP_APPEND], op_seen[OP_INSERT], op_seen[OP_DELETE],
                 op_seen[OP_SWAP], op_seen[OP_RSVD_5] + op_seen[OP_RSVD_6] + op_seen[OP_RSVD_7]);
        if (err_count == 0 && awaited_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
